// ----- hw/rtl/cocc_pkg.sv -----
// Shared types, codes and constants of the circular cell occupancy classifier.
// No dependencies; used by cocc_front, cocc_back, the top level and the testbench.
`default_nettype none

package cocc_pkg;

    localparam int MAP_SIDE_DEF   = 256;
    localparam int MAX_WINDOW_DEF = 32;
    localparam int BLOCK_LIMIT    = 50;

    localparam int CFG_W   = 13;
    localparam int COORD_W = 8;
    localparam int OCC_W   = 8;
    localparam int CTR_W   = 17;
    localparam int POS_W   = 11;
    localparam int SIDE_W  = 9;
    localparam int DIST_W  = 19;
    localparam int R2_W    = 26;
    localparam int BND_W   = 13;
    localparam int RAD_W   = 13;
    localparam int DIM_W   = 9;

    localparam logic [1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_CELL_RADIUS = 2'd2;

    localparam logic OP_WRITE    = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status CS_FREE    = 2'd0;
    localparam t_status CS_UNKNOWN = 2'd1;
    localparam t_status CS_BLOCKED = 2'd2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_RESULT
    } t_bk_state;

    typedef struct packed {
        logic                      op;
        logic                      wr_ok;
        logic [COORD_W-1:0]        map_x;
        logic [COORD_W-1:0]        map_y;
        logic signed [OCC_W-1:0]   occ;
        logic signed [POS_W-1:0]   x0;
        logic signed [POS_W-1:0]   y0;
        logic [SIDE_W-1:0]         side;
        logic signed [CTR_W-1:0]   cx;
        logic signed [CTR_W-1:0]   cy;
        t_status                   prior;
        logic [R2_W-1:0]           r2;
    } t_cmd;

    typedef struct packed {
        logic [BND_W-1:0] w;
        logic [BND_W-1:0] h;
    } t_bounds;

endpackage

`default_nettype wire

// ----- hw/rtl/cocc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cocc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cocc_fifo.sv -----
// Small register FIFO with push/full and pop/empty sides.
// No dependencies; carries command and result beats.
`default_nettype none

module cocc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [NW-1:0]    r_cnt,  n_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == NW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cocc_front.sv -----
// Front end: configuration registers and decode of input beats into commands
// (window origin, side, squared radius). Depends on cocc_pkg.
`default_nettype none

module cocc_front #(
    parameter int MAP_SIDE   = cocc_pkg::MAP_SIDE_DEF,
    parameter int MAX_WINDOW = cocc_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [1:0]                          i_cfg_idx,
    input  wire logic [cocc_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                                i_operation,
    input  wire logic [cocc_pkg::COORD_W-1:0]        i_map_x,
    input  wire logic [cocc_pkg::COORD_W-1:0]        i_map_y,
    input  wire logic signed [cocc_pkg::OCC_W-1:0]   i_occupancy,
    input  wire logic signed [cocc_pkg::CTR_W-1:0]   i_center_x,
    input  wire logic signed [cocc_pkg::CTR_W-1:0]   i_center_y,
    input  wire cocc_pkg::t_status                   i_prior_status,
    output cocc_pkg::t_cmd                           o_cmd,
    output cocc_pkg::t_bounds                        o_bounds
);

    localparam int BW = cocc_pkg::BND_W;
    localparam int DW = cocc_pkg::CTR_W + 1;

    logic [cocc_pkg::DIM_W-1:0] r_map_width;
    logic [cocc_pkg::DIM_W-1:0] r_map_height;
    logic [cocc_pkg::RAD_W-1:0] r_radius;

    logic signed [DW-1:0]                 w_dx, w_dy;
    logic signed [cocc_pkg::POS_W-1:0]    w_x0, w_y0;
    logic [cocc_pkg::RAD_W+1:0]           w_span;
    logic [6:0]                           w_side_raw;
    logic [cocc_pkg::SIDE_W-1:0]          w_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= cocc_pkg::DIM_W'(256);
            r_map_height <= cocc_pkg::DIM_W'(256);
            r_radius     <= cocc_pkg::RAD_W'(512);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cocc_pkg::CFG_MAP_WIDTH:   r_map_width  <= i_cfg_data[cocc_pkg::DIM_W-1:0];
                cocc_pkg::CFG_MAP_HEIGHT:  r_map_height <= i_cfg_data[cocc_pkg::DIM_W-1:0];
                cocc_pkg::CFG_CELL_RADIUS: r_radius     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // origin = trunc toward zero of (center - radius) / 256
    assign w_dx = {i_center_x[cocc_pkg::CTR_W-1], i_center_x} - $signed({5'b0, r_radius});
    assign w_dy = {i_center_y[cocc_pkg::CTR_W-1], i_center_y} - $signed({5'b0, r_radius});
    assign w_x0 = {w_dx[DW-1], w_dx[DW-1:8]}
                + cocc_pkg::POS_W'(w_dx[DW-1] && (|w_dx[7:0]));
    assign w_y0 = {w_dy[DW-1], w_dy[DW-1:8]}
                + cocc_pkg::POS_W'(w_dy[DW-1] && (|w_dy[7:0]));

    assign w_span     = {r_radius, 1'b0} + (cocc_pkg::RAD_W+2)'(255);
    assign w_side_raw = w_span[cocc_pkg::RAD_W+1:8];
    assign w_side     = (cocc_pkg::SIDE_W'(w_side_raw) > cocc_pkg::SIDE_W'(MAX_WINDOW))
                      ? cocc_pkg::SIDE_W'(MAX_WINDOW) : cocc_pkg::SIDE_W'(w_side_raw);

    always_comb begin
        o_cmd.op    = i_operation;
        o_cmd.wr_ok = (BW'(i_map_x) < BW'(MAP_SIDE)) && (BW'(i_map_y) < BW'(MAP_SIDE));
        o_cmd.map_x = i_map_x;
        o_cmd.map_y = i_map_y;
        o_cmd.occ   = i_occupancy;
        o_cmd.x0    = w_x0;
        o_cmd.y0    = w_y0;
        o_cmd.side  = w_side;
        o_cmd.cx    = i_center_x;
        o_cmd.cy    = i_center_y;
        o_cmd.prior = i_prior_status;
        o_cmd.r2    = cocc_pkg::R2_W'(r_radius * r_radius);
    end

    assign o_bounds.w = (BW'(r_map_width) > BW'(MAP_SIDE)) ? BW'(MAP_SIDE) : BW'(r_map_width);
    assign o_bounds.h = (BW'(r_map_height) > BW'(MAP_SIDE)) ? BW'(MAP_SIDE) : BW'(r_map_height);

endmodule

`default_nettype wire

// ----- hw/rtl/cocc_back.sv -----
// Back end: executes map writes and runs the window scan through a three-stage
// pipeline around the map RAM. Depends on cocc_pkg and cocc_ram.
`default_nettype none

module cocc_back #(
    parameter int MAP_SIDE   = cocc_pkg::MAP_SIDE_DEF,
    parameter int MAX_WINDOW = cocc_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire cocc_pkg::t_cmd           i_cmd,
    input  wire logic                     i_cmd_empty,
    output logic                          o_cmd_pop,
    input  wire cocc_pkg::t_bounds        i_bounds,
    output logic                          o_res_push,
    output cocc_pkg::t_status             o_res_data,
    input  wire logic                     i_res_full
);

    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CTW   = $clog2(MAX_WINDOW);
    localparam int PW    = cocc_pkg::POS_W;
    localparam int XW    = cocc_pkg::DIST_W;
    localparam int SW    = cocc_pkg::SIDE_W;
    localparam int BW    = cocc_pkg::BND_W;
    localparam int QW    = 2 * XW;

    cocc_pkg::t_bk_state r_state, n_state;
    cocc_pkg::t_cmd      r_cmd;
    logic [CTW-1:0]      r_col, n_col;
    logic [CTW-1:0]      r_row, n_row;
    logic                r_unk, n_unk;
    logic                r_blk, n_blk;
    logic                r_s1_vld, r_s2_vld;
    logic                w_latch, w_issue, w_ram_we;

    logic signed [PW-1:0] w_px, w_py;
    logic signed [XW-1:0] w_dx, w_dy;
    logic                 w_oob;
    logic [AW-1:0]        w_raddr, w_waddr;
    logic [cocc_pkg::OCC_W-1:0] w_rdata;

    logic signed [XW-1:0] r_s1_dx, r_s1_dy;
    logic                 r_s1_oob;
    logic signed [QW-1:0] w_dx2, w_dy2;
    logic [QW-1:0]        r_s2_dx2, r_s2_dy2;
    logic                 r_s2_oob;
    logic signed [cocc_pkg::OCC_W-1:0] r_s2_occ;
    logic [QW:0]          w_dist;
    logic                 w_in_circ, w_hit, w_unk_now;
    logic                 w_row_last, w_col_last;

    // stage 0: cell position, distance terms, map address
    assign w_px = r_cmd.x0 + PW'(r_col);
    assign w_py = r_cmd.y0 + PW'(r_row);
    assign w_dx = $signed({w_px, 8'h00}) - $signed({{(XW-cocc_pkg::CTR_W){r_cmd.cx[16]}}, r_cmd.cx});
    assign w_dy = $signed({w_py, 8'h00}) - $signed({{(XW-cocc_pkg::CTR_W){r_cmd.cy[16]}}, r_cmd.cy});
    assign w_oob = w_px[PW-1] || w_py[PW-1]
                || (BW'(w_px[PW-2:0]) >= i_bounds.w)
                || (BW'(w_py[PW-2:0]) >= i_bounds.h);
    assign w_raddr = AW'(32'(w_py[PW-2:0]) * 32'(MAP_SIDE) + 32'(w_px[PW-2:0]));
    assign w_waddr = AW'(32'(i_cmd.map_y) * 32'(MAP_SIDE) + 32'(i_cmd.map_x));

    cocc_ram #(
        .WIDTH (cocc_pkg::OCC_W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd.occ),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // stage 1 -> 2: squares and map data
    assign w_dx2 = r_s1_dx * r_s1_dx;
    assign w_dy2 = r_s1_dy * r_s1_dy;

    // stage 2: circle test and decision
    assign w_dist    = {1'b0, r_s2_dx2} + {1'b0, r_s2_dy2};
    assign w_in_circ = (w_dist <= (QW+1)'(r_cmd.r2));
    assign w_hit     = r_s2_vld && w_in_circ && !r_s2_oob
                    && (r_s2_occ > cocc_pkg::OCC_W'(cocc_pkg::BLOCK_LIMIT));
    assign w_unk_now = r_s2_vld && w_in_circ && (r_s2_oob || r_s2_occ[cocc_pkg::OCC_W-1]);

    assign w_row_last = (SW'(r_row) == r_cmd.side - 1'b1);
    assign w_col_last = (SW'(r_col) == r_cmd.side - 1'b1);

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_unk      = r_unk | w_unk_now;
        n_blk      = r_blk;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        w_ram_we   = 1'b0;
        w_latch    = 1'b0;
        w_issue    = 1'b0;
        unique case (r_state)
            cocc_pkg::BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == cocc_pkg::OP_WRITE) begin
                        w_ram_we = i_cmd.wr_ok;
                    end else begin
                        w_latch = 1'b1;
                        n_unk   = 1'b0;
                        n_blk   = 1'b0;
                        n_col   = '0;
                        n_row   = '0;
                        n_state = (i_cmd.side == '0) ? cocc_pkg::BK_RESULT
                                                     : cocc_pkg::BK_SCAN;
                    end
                end
            end
            cocc_pkg::BK_SCAN: begin
                if (w_hit) begin
                    n_blk   = 1'b1;
                    n_state = cocc_pkg::BK_RESULT;
                end else begin
                    w_issue = 1'b1;
                    if (w_row_last) begin
                        n_row = '0;
                        if (w_col_last) begin
                            n_state = cocc_pkg::BK_DRAIN;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            cocc_pkg::BK_DRAIN: begin
                if (w_hit) begin
                    n_blk   = 1'b1;
                    n_state = cocc_pkg::BK_RESULT;
                end else if (!r_s1_vld) begin
                    n_state = cocc_pkg::BK_RESULT;
                end
            end
            cocc_pkg::BK_RESULT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = cocc_pkg::BK_IDLE;
                end
            end
            default: n_state = cocc_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        priority if (r_blk) begin
            o_res_data = cocc_pkg::CS_BLOCKED;
        end else if (r_unk && r_cmd.prior == cocc_pkg::CS_UNKNOWN) begin
            o_res_data = cocc_pkg::CS_UNKNOWN;
        end else if (r_unk && r_cmd.prior == cocc_pkg::CS_BLOCKED) begin
            o_res_data = cocc_pkg::CS_BLOCKED;
        end else begin
            o_res_data = cocc_pkg::CS_FREE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cocc_pkg::BK_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_unk    <= 1'b0;
            r_blk    <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_row    <= n_row;
            r_unk    <= n_unk;
            r_blk    <= n_blk;
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld && !w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_latch) begin
            r_cmd <= i_cmd;
        end
        r_s1_dx  <= w_dx;
        r_s1_dy  <= w_dy;
        r_s1_oob <= w_oob;
        r_s2_dx2 <= $unsigned(w_dx2);
        r_s2_dy2 <= $unsigned(w_dy2);
        r_s2_oob <= r_s1_oob;
        r_s2_occ <= $signed(w_rdata);
    end

    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cocc_pkg::BK_IDLE || r_state == cocc_pkg::BK_RESULT)
            |-> (!r_s1_vld && !r_s2_vld))
        else $error("scan pipeline busy outside a scan");

    a_s2_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (r_state == cocc_pkg::BK_SCAN || r_state == cocc_pkg::BK_DRAIN))
        else $error("cell evaluated outside a scan");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == cocc_pkg::BK_IDLE && !r_s1_vld))
        else $error("map write during a scan");

    a_push_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> (r_state == cocc_pkg::BK_IDLE && !r_s2_vld))
        else $error("result beat not followed by idle");

endmodule

`default_nettype wire

// ----- hw/rtl/circular_cell_occupancy_classifier.sv -----
// Circular cell occupancy classifier: occupancy map with circular window scan.
// Top level; instantiates cocc_front, cocc_fifo and cocc_back; uses cocc_pkg.
//
// Usage:
//   Input beats enter on push while full is low. operation 0 writes one map
//   cell (map_x, map_y, occupancy); operation 1 classifies a circle given by
//   center_x/center_y (Q8.8) and the configured cell_radius, with
//   prior_status. Each classify beat yields one cell_status beat; writes
//   yield none. Results leave in order: cell_status is valid while empty is
//   low and is taken on pop. The user, not the block, is bound by this rule:
//   Configuration (i_cfg_we/i_cfg_idx/i_cfg_data) must be written while idle.
// Flow:
//   A write beat reaches the map RAM in the cycle it is popped. A classify
//   beat scans side*side cells, side = min(ceil(2*radius/256), MAX_WINDOW),
//   with one map RAM read per scanned cell; it ends early on the first blocked
//   cell. A two-beat command queue lets the front keep accepting while a
//   scan runs, and a two-beat result queue holds results while pop is low;
//   when it is full the back end waits and the command queue fills.
// Reset:
//   Clears queues, scan control and configuration (256, 256, 512). The map
//   RAM is not cleared; cells are undefined until written.
`default_nettype none

module circular_cell_occupancy_classifier #(
    parameter int MAP_SIDE   = cocc_pkg::MAP_SIDE_DEF,
    parameter int MAX_WINDOW = cocc_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                i_operation,
    input  wire logic [cocc_pkg::COORD_W-1:0]        i_map_x,
    input  wire logic [cocc_pkg::COORD_W-1:0]        i_map_y,
    input  wire logic signed [cocc_pkg::OCC_W-1:0]   i_occupancy,
    input  wire logic signed [cocc_pkg::CTR_W-1:0]   i_center_x,
    input  wire logic signed [cocc_pkg::CTR_W-1:0]   i_center_y,
    input  wire logic [1:0]                          i_prior_status,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [1:0]                               o_cell_status,
    input  wire logic                                i_cfg_we,
    input  wire logic [1:0]                          i_cfg_idx,
    input  wire logic [cocc_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int CMDW = $bits(cocc_pkg::t_cmd);

    cocc_pkg::t_cmd    w_front_cmd;
    cocc_pkg::t_cmd    w_back_cmd;
    cocc_pkg::t_bounds w_bounds;
    logic [CMDW-1:0]   w_cmd_q;
    logic              w_cmd_empty, w_cmd_pop;
    logic              w_res_push, w_res_full;
    cocc_pkg::t_status w_res_data;

    cocc_front #(
        .MAP_SIDE   (MAP_SIDE),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_map_x        (i_map_x),
        .i_map_y        (i_map_y),
        .i_occupancy    (i_occupancy),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_prior_status (i_prior_status),
        .o_cmd          (w_front_cmd),
        .o_bounds       (w_bounds)
    );

    cocc_fifo #(
        .WIDTH (CMDW),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_q),
        .o_empty (w_cmd_empty)
    );

    assign w_back_cmd = cocc_pkg::t_cmd'(w_cmd_q);

    cocc_back #(
        .MAP_SIDE   (MAP_SIDE),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_back_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_bounds    (w_bounds),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_data),
        .i_res_full  (w_res_full)
    );

    cocc_fifo #(
        .WIDTH (2),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_cell_status),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for circular_cell_occupancy_classifier: directed table,
// then randomized map writes and circle classifications over several configurations.
// Depends on cocc_pkg and the circular_cell_occupancy_classifier RTL.

module testbench;

    import cocc_pkg::*;

    localparam logic signed [CTR_W-1:0] CTR_MIN = 17'h10000;
    localparam logic signed [CTR_W-1:0] CTR_MAX = 17'h0FFFF;
    localparam t_status CS_RESERVED = 2'd3;
    localparam int WRITE_SETTLE = 40;
    localparam int END_SETTLE   = 60;
    localparam int RX_HOLD      = 600;

    typedef struct packed {
        logic                    op;
        logic [COORD_W-1:0]      mx;
        logic [COORD_W-1:0]      my;
        logic signed [OCC_W-1:0] occ;
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        t_status                 prior;
        logic                    has_exp;
        t_status                 exp_status;
    } t_beat;

    // op, x, y, occupancy, center x, center y, prior, typed, expected
    localparam t_beat DIR_TAB [22] = '{
        '{OP_WRITE,    8'd0,   8'd0,   8'h80,  17'sd0,  17'sd0,  CS_FREE,     1'b0, CS_FREE},
        '{OP_WRITE,    8'd1,   8'd0,   8'd0,   17'sd0,  17'sd0,  CS_FREE,     1'b0, CS_FREE},
        '{OP_WRITE,    8'd0,   8'd1,   8'd50,  17'sd0,  17'sd0,  CS_FREE,     1'b0, CS_FREE},
        '{OP_WRITE,    8'd1,   8'd1,   8'd0,   17'sd0,  17'sd0,  CS_FREE,     1'b0, CS_FREE},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   CTR_MIN, CTR_MIN, CS_UNKNOWN,  1'b1, CS_UNKNOWN},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   CTR_MIN, CTR_MIN, CS_BLOCKED,  1'b1, CS_BLOCKED},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   CTR_MIN, CTR_MIN, CS_FREE,     1'b1, CS_FREE},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   CTR_MIN, CTR_MIN, CS_RESERVED, 1'b1, CS_FREE},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   17'sd0,  17'sd0,  CS_RESERVED, 1'b1, CS_FREE},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   17'sd0,  17'sd0,  CS_UNKNOWN,  1'b1, CS_UNKNOWN},
        '{OP_WRITE,    8'd1,   8'd1,   8'd51,  17'sd0,  17'sd0,  CS_FREE,     1'b0, CS_FREE},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   17'sd0,  17'sd0,  CS_FREE,     1'b1, CS_BLOCKED},
        '{OP_WRITE,    8'd1,   8'd1,   8'h7F,  17'sd0,  17'sd0,  CS_FREE,     1'b0, CS_FREE},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   17'sd0,  17'sd0,  CS_BLOCKED,  1'b1, CS_BLOCKED},
        '{OP_WRITE,    8'd255, 8'd255, 8'h7F,  17'sd0,  17'sd0,  CS_FREE,     1'b0, CS_FREE},
        '{OP_WRITE,    8'd255, 8'd0,   8'hFF,  17'sd0,  17'sd0,  CS_FREE,     1'b0, CS_FREE},
        '{OP_WRITE,    8'd0,   8'd255, 8'd100, 17'sd0,  17'sd0,  CS_FREE,     1'b0, CS_FREE},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   CTR_MAX, CTR_MAX, CS_UNKNOWN,  1'b0, CS_FREE},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   CTR_MAX, CTR_MIN, CS_BLOCKED,  1'b1, CS_BLOCKED},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   CTR_MIN, CTR_MAX, CS_UNKNOWN,  1'b1, CS_UNKNOWN},
        '{OP_CLASSIFY, 8'd0,   8'd0,   8'd0,   17'sd384, 17'sd384, CS_FREE,   1'b0, CS_FREE},
        '{OP_WRITE,    8'd128, 8'd128, 8'hFF,  17'sd0,  17'sd0,  CS_FREE,     1'b0, CS_FREE}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic                    i_operation;
    logic [COORD_W-1:0]      i_map_x;
    logic [COORD_W-1:0]      i_map_y;
    logic signed [OCC_W-1:0] i_occupancy;
    logic signed [CTR_W-1:0] i_center_x;
    logic signed [CTR_W-1:0] i_center_y;
    logic [1:0]              i_prior_status;
    logic                    empty;
    logic                    pop;
    logic [1:0]              o_cell_status;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;

    circular_cell_occupancy_classifier u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_map_x        (i_map_x),
        .i_map_y        (i_map_y),
        .i_occupancy    (i_occupancy),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_prior_status (i_prior_status),
        .empty          (empty),
        .pop            (pop),
        .o_cell_status  (o_cell_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    logic signed [OCC_W-1:0] occ_model [0:65535];
    bit                      cell_written [0:65535];
    logic [DIM_W-1:0]        cfg_w;
    logic [DIM_W-1:0]        cfg_h;
    logic [RAD_W-1:0]        cfg_r;
    t_status                 pending_status [$];
    int                      fill_cells [$];
    int                      beats_sent;
    int                      n_errors;
    bit                      no_idle;
    bit                      rx_hold_req;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(20_000_000);
        $display("circular_cell_occupancy_classifier test failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Walks the circle window. With list_unwritten set, it collects in-map cells never
    // written (and marks them), else it returns the predicted status.
    function automatic t_status scan_circle(logic signed [CTR_W-1:0] cx_q,
                                            logic signed [CTR_W-1:0] cy_q,
                                            t_status prior, bit list_unwritten);
        longint r, r2, cx, cy, x0, y0, w, h, px, py, dx, dy, side;
        int addr;
        bit unk;
        r = cfg_r;
        r2 = r * r;
        cx = cx_q;
        cy = cy_q;
        x0 = (cx - r) / 256;
        y0 = (cy - r) / 256;
        w = (cfg_w > MAP_SIDE_DEF) ? MAP_SIDE_DEF : cfg_w;
        h = (cfg_h > MAP_SIDE_DEF) ? MAP_SIDE_DEF : cfg_h;
        side = (2 * r + 255) / 256;
        if (side > MAX_WINDOW_DEF)
            side = MAX_WINDOW_DEF;
        unk = 1'b0;
        for (longint i = 0; i < side; i++) begin
            for (longint j = 0; j < side; j++) begin
                px = x0 + i;
                py = y0 + j;
                dx = px * 256 - cx;
                dy = py * 256 - cy;
                if (dx * dx + dy * dy > r2)
                    continue;
                if (px < 0 || py < 0 || px >= w || py >= h) begin
                    unk = 1'b1;
                    continue;
                end
                addr = int'(py * MAP_SIDE_DEF + px);
                if (list_unwritten) begin
                    if (!cell_written[addr]) begin
                        cell_written[addr] = 1'b1;
                        fill_cells.push_back(addr);
                    end
                end else if (occ_model[addr] > BLOCK_LIMIT) begin
                    return CS_BLOCKED;
                end else if (occ_model[addr] < 0) begin
                    unk = 1'b1;
                end
            end
        end
        if (unk && prior == CS_UNKNOWN)
            return CS_UNKNOWN;
        if (unk && prior == CS_BLOCKED)
            return CS_BLOCKED;
        return CS_FREE;
    endfunction

    function automatic logic signed [OCC_W-1:0] rand_occ(int pct_clear);
        int r;
        r = $urandom_range(0, 99);
        if (r < pct_clear)
            return $urandom_range(0, 50);
        if (r < pct_clear + (100 - pct_clear) / 2)
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom_range(128, 255));
        return $urandom_range(51, 127);
    endfunction

    function automatic t_beat rand_beat(logic op);
        t_beat b;
        b = t_beat'({$urandom, $urandom, $urandom});
        b.op = op;
        b.has_exp = 1'b0;
        return b;
    endfunction

    task automatic send_beat(t_beat b);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_operation    <= b.op;
        i_map_x        <= b.mx;
        i_map_y        <= b.my;
        i_occupancy    <= b.occ;
        i_center_x     <= b.cx;
        i_center_y     <= b.cy;
        i_prior_status <= b.prior;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        if (b.op == OP_WRITE)
            occ_model[{b.my, b.mx}] = b.occ;
        else if (b.has_exp)
            pending_status.push_back(b.exp_status);
        else
            pending_status.push_back(scan_circle(b.cx, b.cy, b.prior, 1'b0));
        beats_sent++;
    endtask

    // Writes every unwritten cell the circle can read, then the classify beat itself.
    task automatic send_classify(t_beat b);
        t_beat fb;
        int addr;
        void'(scan_circle(b.cx, b.cy, b.prior, 1'b1));
        while (fill_cells.size() != 0) begin
            addr = fill_cells.pop_front();
            fb = rand_beat(OP_WRITE);
            fb.mx = addr[7:0];
            fb.my = addr[15:8];
            fb.occ = rand_occ(90);
            send_beat(fb);
        end
        send_beat(b);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (WRITE_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        case (idx)
            CFG_MAP_WIDTH:   cfg_w = DIM_W'(val);
            CFG_MAP_HEIGHT:  cfg_h = DIM_W'(val);
            CFG_CELL_RADIUS: cfg_r = RAD_W'(val);
            default: ;
        endcase
    endtask

    task automatic run_phase(int w, int h, int r, int quota, bit hold);
        t_beat b;
        int start;
        bit near;
        drain_results();
        cfg_write(CFG_MAP_WIDTH, w);
        cfg_write(CFG_MAP_HEIGHT, h);
        cfg_write(CFG_CELL_RADIUS, r);
        i_cfg_we <= 1'b0;
        no_idle = ($urandom_range(0, 3) == 0);
        if (hold)
            rx_hold_req = 1'b1;
        near = (r > 1024);
        start = beats_sent;
        while (beats_sent - start < quota) begin
            if ($urandom_range(0, 9) < 3) begin
                b = rand_beat(OP_WRITE);
                if ($urandom_range(0, 99) < 65) begin
                    b.mx = $urandom_range(0, 31);
                    b.my = $urandom_range(0, 31);
                end
                b.occ = rand_occ(60);
                cell_written[{b.my, b.mx}] = 1'b1;
                send_beat(b);
            end else begin
                b = rand_beat(OP_CLASSIFY);
                if (near || $urandom_range(0, 6) != 0) begin
                    b.cx = CTR_W'($urandom_range(0, 36 * 256)) - CTR_W'(6 * 256);
                    b.cy = CTR_W'($urandom_range(0, 36 * 256)) - CTR_W'(6 * 256);
                end
                send_classify(b);
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        i_operation    <= OP_WRITE;
        i_map_x        <= '0;
        i_map_y        <= '0;
        i_occupancy    <= '0;
        i_center_x     <= '0;
        i_center_y     <= '0;
        i_prior_status <= CS_FREE;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_MAP_WIDTH;
        i_cfg_data     <= '0;
        cfg_w = 9'd256;
        cfg_h = 9'd256;
        cfg_r = 13'd512;
        beats_sent = 0;
        no_idle = 1'b0;
        rx_hold_req = 1'b0;
        for (int a = 0; a < 65536; a++) begin
            occ_model[a] = '0;
            cell_written[a] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < $size(DIR_TAB); k++) begin
            if (DIR_TAB[k].op == OP_WRITE) begin
                cell_written[{DIR_TAB[k].my, DIR_TAB[k].mx}] = 1'b1;
                send_beat(DIR_TAB[k]);
            end else begin
                send_classify(DIR_TAB[k]);
            end
        end

        run_phase(511, 300, 384, 140, 1'b0);
        run_phase(16, 12, 256, 140, 1'b1);
        run_phase(1, 1, 1, 140, 1'b0);
        run_phase(0, 256, 0, 140, 1'b0);
        run_phase(256, 256, 700, 140, 1'b0);
        run_phase(256, 8, 4096, 40, 1'b0);
        run_phase(24, 24, 8191, 40, 1'b0);
        run_phase(256, 256, 512, 140, 1'b1);

        push <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("circular_cell_occupancy_classifier test passed");
        end else begin
            $display("circular_cell_occupancy_classifier test failed");
        end
        $finish;
    end

    initial begin
        int rx_gap;
        int hold_left;
        t_status want;
        rx_gap = 0;
        hold_left = 0;
        n_errors = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (pending_status.size() == 0) begin
                    $error("cell_status beat with no expected result: got %0d", o_cell_status);
                    n_errors++;
                end else begin
                    want = pending_status.pop_front();
                    if (o_cell_status !== want) begin
                        $error("cell_status mismatch: expected %0d, got %0d",
                               want, o_cell_status);
                        n_errors++;
                    end
                end
                rx_gap = idle_len();
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = RX_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

endmodule
